/* sv/msh_pkg.sv */
// Package with the turn encoding, command codes and the turn collapse table.
`timescale 1ns / 1ps

package msh_pkg;

  typedef logic [1:0] turn_t;
  typedef logic [1:0] cmd_t;

  // Turn symbols.
  localparam turn_t TURN_LEFT     = 2'd0;
  localparam turn_t TURN_STRAIGHT = 2'd1;
  localparam turn_t TURN_RIGHT    = 2'd2;
  localparam turn_t TURN_BACK     = 2'd3;

  // Command codes.
  localparam cmd_t CMD_PUSH  = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  // Outcome of one check of the top three entries.
  typedef struct packed {
    logic  hit;
    turn_t turn;
  } collapse_t;

  // Single turn that replaces the sequence x, back, y (x and y not back).
  function automatic turn_t collapse_turn(input turn_t x, input turn_t y);
    turn_t res;
    case ({x, y})
      {TURN_LEFT,     TURN_LEFT}:     res = TURN_STRAIGHT;
      {TURN_LEFT,     TURN_STRAIGHT}: res = TURN_RIGHT;
      {TURN_LEFT,     TURN_RIGHT}:    res = TURN_BACK;
      {TURN_STRAIGHT, TURN_LEFT}:     res = TURN_RIGHT;
      {TURN_STRAIGHT, TURN_STRAIGHT}: res = TURN_BACK;
      {TURN_STRAIGHT, TURN_RIGHT}:    res = TURN_LEFT;
      {TURN_RIGHT,    TURN_LEFT}:     res = TURN_BACK;
      {TURN_RIGHT,    TURN_STRAIGHT}: res = TURN_LEFT;
      {TURN_RIGHT,    TURN_RIGHT}:    res = TURN_STRAIGHT;
      default:                        res = TURN_LEFT;
    endcase
    return res;
  endfunction

endpackage

/* sv/msh_stack_ram.sv */
// Turn stack memory: one write port and two registered read ports.
`timescale 1ns / 1ps

module msh_stack_ram
  import msh_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  turn_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output turn_t         rd_data_a,
  output turn_t         rd_data_b
);

  turn_t mem [DEPTH];

  // Write and registered reads; the sequencer never reads the address it writes.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* sv/msh_collapse_unit.sv */
// Shared check unit: matches x, back, y on the stack top and gives the collapsed turn.
`timescale 1ns / 1ps

module msh_collapse_unit
  import msh_pkg::*;
(
  input  turn_t     x,
  input  turn_t     b,
  input  turn_t     y,
  output collapse_t result
);

  // A collapse needs a back turn in the middle and none on either side.
  always_comb begin
    result.hit  = (b == TURN_BACK) && (x != TURN_BACK) && (y != TURN_BACK);
    result.turn = collapse_turn(x, y);
  end

endmodule

/* sv/maze_path_shortener.sv */
// Maze path shortener: turn stack with online dead-end elimination.
// A push gives its result directly when the stack then holds fewer than three entries, else it
// reads the two entries below the new top and checks again after each collapse that leaves
// three or more entries; an in-range read passes the read state; others answer directly.
// One item at a time: input stalls while an item is in work or its result is not taken.
// Reset clears depth, raw count and control; stack memory contents are not cleared.
`timescale 1ns / 1ps

module maze_path_shortener
  import msh_pkg::*;
#(
  parameter int MAX_TURNS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [1:0] turn,
  input  logic [7:0] entry_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] read_turn,
  output logic [8:0] path_depth,
  output logic       dropped,
  output logic       index_valid
);

  localparam int AW = $clog2(MAX_TURNS);
  localparam int DW = $clog2(MAX_TURNS + 1);
  localparam int CW = (DW > 8) ? DW : 8;
  localparam int PW = (DW > 9) ? DW : 9;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;

  logic [1:0]    state, state_next;
  logic [DW-1:0] depth, depth_next;
  logic [DW-1:0] raw_count, raw_count_next;
  turn_t         cur, cur_next;
  logic          out_valid_next;
  turn_t         read_turn_next;
  logic          dropped_next;
  logic          index_valid_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  turn_t         wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  turn_t         rd_data_a;
  turn_t         rd_data_b;
  collapse_t     chk;

  logic          accept;
  logic          out_take;
  logic [DW-1:0] depth_m1, depth_m2, depth_m3, depth_m4, depth_m5;
  logic [CW-1:0] idx_ext;
  logic [CW-1:0] depth_cw;
  logic [PW-1:0] depth_pw;

  msh_stack_ram #(
    .DEPTH (MAX_TURNS),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  msh_collapse_unit u_collapse (
    .x      (rd_data_a),
    .b      (rd_data_b),
    .y      (cur),
    .result (chk)
  );

  // Handshake and address arithmetic.
  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign depth_m1 = depth - DW'(1);
  assign depth_m2 = depth - DW'(2);
  assign depth_m3 = depth - DW'(3);
  assign depth_m4 = depth - DW'(4);
  assign depth_m5 = depth - DW'(5);
  assign idx_ext  = CW'(entry_index);
  assign depth_cw = CW'(depth);
  assign depth_pw = PW'(depth);

  // Depth only changes while no result is pending, so it is reported straight from the register.
  assign path_depth = depth_pw[8:0];

  // Sequencer: decodes a beat, then reads or walks the collapse cascade.
  always_comb begin
    state_next       = state;
    depth_next       = depth;
    raw_count_next   = raw_count;
    cur_next         = cur;
    out_valid_next   = out_valid && !out_take;
    read_turn_next   = read_turn;
    dropped_next     = dropped;
    index_valid_next = index_valid;
    wr_en            = 1'b0;
    wr_addr          = depth[AW-1:0];
    wr_data          = turn;
    rd_en            = 1'b0;
    rd_addr_a        = depth_m2[AW-1:0];
    rd_addr_b        = depth_m2[AW-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          read_turn_next   = TURN_LEFT;
          dropped_next     = 1'b0;
          index_valid_next = 1'b0;
          case (command)
            CMD_PUSH: begin
              if (raw_count >= DW'(MAX_TURNS) || depth >= DW'(MAX_TURNS)) begin
                dropped_next   = 1'b1;
                out_valid_next = 1'b1;
              end else begin
                wr_en          = 1'b1;
                depth_next     = depth + DW'(1);
                raw_count_next = raw_count + DW'(1);
                cur_next       = turn;
                if (depth >= DW'(2)) begin
                  // Fetch the two entries below the new top.
                  rd_en      = 1'b1;
                  rd_addr_a  = depth_m2[AW-1:0];
                  rd_addr_b  = depth_m1[AW-1:0];
                  state_next = S_CHECK;
                end else begin
                  out_valid_next = 1'b1;
                end
              end
            end
            CMD_READ: begin
              if (idx_ext < depth_cw) begin
                rd_en      = 1'b1;
                rd_addr_a  = idx_ext[AW-1:0];
                state_next = S_READ;
              end else begin
                out_valid_next = 1'b1;
              end
            end
            CMD_CLEAR: begin
              depth_next     = '0;
              raw_count_next = '0;
              out_valid_next = 1'b1;
            end
            default: begin
              out_valid_next = 1'b1;
            end
          endcase
        end
      end

      S_READ: begin
        read_turn_next   = rd_data_a;
        index_valid_next = 1'b1;
        out_valid_next   = 1'b1;
        state_next       = S_IDLE;
      end

      S_CHECK: begin
        if (chk.hit) begin
          // Replace x, back, y by one turn and look one level further down.
          wr_en      = 1'b1;
          wr_addr    = depth_m3[AW-1:0];
          wr_data    = chk.turn;
          depth_next = depth_m2;
          cur_next   = chk.turn;
          if (depth >= DW'(5)) begin
            rd_en     = 1'b1;
            rd_addr_a = depth_m5[AW-1:0];
            rd_addr_b = depth_m4[AW-1:0];
          end else begin
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      depth     <= '0;
      raw_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      depth     <= depth_next;
      raw_count <= raw_count_next;
      out_valid <= out_valid_next;
    end
    cur         <= cur_next;
    read_turn   <= read_turn_next;
    dropped     <= dropped_next;
    index_valid <= index_valid_next;
  end

endmodule
